// ----- rtl/rsi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_pkg
// Types, widths and helpers for the ray/sphere intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int RAD_W     = 31;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = COORD_W + DIFF_W;
	localparam int SQ_W      = 2 * COORD_W;
	localparam int R2_W      = 2 * RAD_W;
	localparam int WIDE_W    = 128;
	localparam int X2_W      = WIDE_W + 2;
	localparam int H_W       = PROD_W + 2;
	localparam int DISC_W    = SQ_W + R2_W;
	localparam int ROOT_W    = DISC_W / 2;
	localparam int NUM_W     = H_W;
	localparam int Q_W       = 31;
	localparam int ASH_W     = SQ_W + Q_W;
	localparam int DIV_W     = (NUM_W + FRAC_BITS > ASH_W) ? NUM_W + FRAC_BITS : ASH_W;

	localparam logic [COORD_W-1:0] DIST_MAX = {1'b0, {(COORD_W-1){1'b1}}};

	typedef struct packed {
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic signed [COORD_W-1:0] origin_z;
		logic signed [COORD_W-1:0] dir_x;
		logic signed [COORD_W-1:0] dir_y;
		logic signed [COORD_W-1:0] dir_z;
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic signed [COORD_W-1:0] center_z;
		logic        [RAD_W-1:0]   radius;
		logic signed [COORD_W-1:0] nearest_so_far;
	} in_t;

	typedef struct packed {
		logic                      is_hit;
		logic signed [COORD_W-1:0] distance;
	} out_t;

	typedef struct packed {
		logic                      miss;
		logic signed [H_W-1:0]     h;
		logic        [SQ_W-1:0]    a;
		logic signed [COORD_W-1:0] near;
	} ctl_t;

	// 64x64 product from four 32x32 partials
	function automatic logic [WIDE_W-1:0] sum_pp(input logic [63:0] p00,
			input logic [63:0] p01, input logic [63:0] p10, input logic [63:0] p11);
		return WIDE_W'(p00) + (WIDE_W'(p01) << 32) + (WIDE_W'(p10) << 32)
			+ (WIDE_W'(p11) << 64);
	endfunction

endpackage

// ----- rtl/ray_sphere_intersect_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_intersect_top
// Fixed-point ray/sphere hit test, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   item/item_valid/item_stall carries one ray, sphere and nearest distance
//   per transaction; result/result_valid/result_stall returns is_hit and the
//   updated distance, one result per transaction, in order.
//   Throughput: one transaction per cycle; the depth is set by the 63-stage
//   bit-per-stage square root and the 31-stage restoring divider.
//   Every stage advances together; while result_valid is high and
//   result_stall is high the whole pipeline holds and item_stall is raised,
//   so nothing is lost or repeated. Bubbles travel as invalid stages.
//   Reset (arst_n low) clears all valid bits; no transaction is in flight
//   afterward and the block accepts immediately.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_top
	import rsi_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  in_t  item,
	input  logic item_valid,
	output logic item_stall,
	output out_t result,
	output logic result_valid,
	input  logic result_stall
);

	logic en;
	assign en         = !(result_valid && result_stall);
	assign item_stall = !en;

	// stage 1: differences
	logic                      v_s1;
	logic signed [COORD_W-1:0] d_s1 [3];
	logic signed [DIFF_W-1:0]  p_s1 [3];
	logic        [RAD_W-1:0]   rad_s1;
	logic signed [COORD_W-1:0] near_s1;

	// stage 2: products
	logic                      v_s2;
	logic        [SQ_W-1:0]    dd_s2 [3];
	logic signed [PROD_W-1:0]  dp_s2 [3];
	logic signed [PROD_W-1:0]  xa_s2 [3];
	logic signed [PROD_W-1:0]  xb_s2 [3];
	logic        [R2_W-1:0]    r2_s2;
	logic signed [COORD_W-1:0] near_s2;

	// stage 3: a, h, cross magnitudes
	logic                      v_s3;
	logic        [SQ_W-1:0]    a_s3;
	logic signed [H_W-1:0]     h_s3;
	logic        [SQ_W-1:0]    xm_s3 [3];
	logic        [R2_W-1:0]    r2_s3;
	logic signed [COORD_W-1:0] near_s3;

	// stage 4: partial products
	logic       v_s4;
	ctl_t       ctl_s4;
	logic [63:0] arp_s4 [4];
	logic [63:0] xp_s4  [3][4];

	// stage 5..7
	logic              v_s5, v_s6;
	ctl_t              ctl_s5, ctl_s6;
	logic [WIDE_W-1:0] ar2_s5, ar2_s6;
	logic [WIDE_W-1:0] xs2_s5 [3];
	logic [X2_W-1:0]   x2_s6;
	logic [X2_W-1:0]   dfull;

	// square root pipeline, index 0 is its input
	logic              sq_v_s   [0:ROOT_W];
	ctl_t              sq_ctl_s [0:ROOT_W];
	logic [DISC_W-1:0] sq_rem_s [0:ROOT_W];
	logic [ROOT_W-1:0] sq_res_s [0:ROOT_W];

	// root select
	logic             v_rs;
	ctl_t             ctl_rs;
	logic [NUM_W-1:0] num_rs;

	// division pipeline, index 0 is its input
	logic             dv_v_s   [0:Q_W];
	ctl_t             dv_ctl_s [0:Q_W];
	logic             dv_sat_s [0:Q_W];
	logic [DIV_W-1:0] dv_rem_s [0:Q_W];
	logic [Q_W-1:0]   dv_q_s   [0:Q_W];

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			v_s5         <= 1'b0;
			v_s6         <= 1'b0;
			sq_v_s[0]    <= 1'b0;
			v_rs         <= 1'b0;
			dv_v_s[0]    <= 1'b0;
			result_valid <= 1'b0;
		end else if (en) begin
			v_s1         <= item_valid;
			v_s2         <= v_s1;
			v_s3         <= v_s2;
			v_s4         <= v_s3;
			v_s5         <= v_s4;
			v_s6         <= v_s5;
			sq_v_s[0]    <= v_s6;
			v_rs         <= sq_v_s[ROOT_W];
			dv_v_s[0]    <= v_rs;
			result_valid <= dv_v_s[Q_W];
		end
	end

	// ---------------- stages 1..7 ----------------
	assign dfull = X2_W'(ar2_s6) - x2_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= item.dir_x;
			d_s1[1] <= item.dir_y;
			d_s1[2] <= item.dir_z;
			p_s1[0] <= DIFF_W'(item.origin_x) - DIFF_W'(item.center_x);
			p_s1[1] <= DIFF_W'(item.origin_y) - DIFF_W'(item.center_y);
			p_s1[2] <= DIFF_W'(item.origin_z) - DIFF_W'(item.center_z);
			rad_s1  <= item.radius;
			near_s1 <= item.nearest_so_far;

			for (int i = 0; i < 3; i++) begin
				dd_s2[i] <= $unsigned(SQ_W'(d_s1[i]) * SQ_W'(d_s1[i]));
				dp_s2[i] <= PROD_W'(d_s1[i]) * PROD_W'(p_s1[i]);
			end
			xa_s2[0] <= PROD_W'(d_s1[1]) * PROD_W'(p_s1[2]);
			xb_s2[0] <= PROD_W'(d_s1[2]) * PROD_W'(p_s1[1]);
			xa_s2[1] <= PROD_W'(d_s1[2]) * PROD_W'(p_s1[0]);
			xb_s2[1] <= PROD_W'(d_s1[0]) * PROD_W'(p_s1[2]);
			xa_s2[2] <= PROD_W'(d_s1[0]) * PROD_W'(p_s1[1]);
			xb_s2[2] <= PROD_W'(d_s1[1]) * PROD_W'(p_s1[0]);
			r2_s2    <= R2_W'(rad_s1) * R2_W'(rad_s1);
			near_s2  <= near_s1;

			a_s3 <= dd_s2[0] + dd_s2[1] + dd_s2[2];
			h_s3 <= H_W'(dp_s2[0]) + H_W'(dp_s2[1]) + H_W'(dp_s2[2]);
			for (int i = 0; i < 3; i++) begin
				xm_s3[i] <= (PROD_W+1)'(xa_s2[i]) < (PROD_W+1)'(xb_s2[i])
					? SQ_W'((PROD_W+1)'(xb_s2[i]) - (PROD_W+1)'(xa_s2[i]))
					: SQ_W'((PROD_W+1)'(xa_s2[i]) - (PROD_W+1)'(xb_s2[i]));
			end
			r2_s3   <= r2_s2;
			near_s3 <= near_s2;

			ctl_s4.miss <= (a_s3 == '0);
			ctl_s4.h    <= h_s3;
			ctl_s4.a    <= a_s3;
			ctl_s4.near <= near_s3;
			arp_s4[0] <= 64'(a_s3[31:0])  * 64'(r2_s3[31:0]);
			arp_s4[1] <= 64'(a_s3[31:0])  * 64'(r2_s3[R2_W-1:32]);
			arp_s4[2] <= 64'(a_s3[63:32]) * 64'(r2_s3[31:0]);
			arp_s4[3] <= 64'(a_s3[63:32]) * 64'(r2_s3[R2_W-1:32]);
			for (int i = 0; i < 3; i++) begin
				xp_s4[i][0] <= 64'(xm_s3[i][31:0])  * 64'(xm_s3[i][31:0]);
				xp_s4[i][1] <= 64'(xm_s3[i][31:0])  * 64'(xm_s3[i][63:32]);
				xp_s4[i][2] <= 64'(xm_s3[i][63:32]) * 64'(xm_s3[i][31:0]);
				xp_s4[i][3] <= 64'(xm_s3[i][63:32]) * 64'(xm_s3[i][63:32]);
			end

			ctl_s5 <= ctl_s4;
			ar2_s5 <= sum_pp(arp_s4[0], arp_s4[1], arp_s4[2], arp_s4[3]);
			for (int i = 0; i < 3; i++) begin
				xs2_s5[i] <= sum_pp(xp_s4[i][0], xp_s4[i][1], xp_s4[i][2], xp_s4[i][3]);
			end

			ctl_s6 <= ctl_s5;
			ar2_s6 <= ar2_s5;
			x2_s6  <= X2_W'(xs2_s5[0]) + X2_W'(xs2_s5[1]) + X2_W'(xs2_s5[2]);

			sq_ctl_s[0].miss <= ctl_s6.miss || (x2_s6 > X2_W'(ar2_s6));
			sq_ctl_s[0].h    <= ctl_s6.h;
			sq_ctl_s[0].a    <= ctl_s6.a;
			sq_ctl_s[0].near <= ctl_s6.near;
			sq_rem_s[0]      <= dfull[DISC_W-1:0];
			sq_res_s[0]      <= '0;
		end
	end

	// ---------------- square root, one bit per stage ----------------
	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		localparam int B = ROOT_W - 1 - k;
		logic [DISC_W:0] trial;
		logic            take;

		always_comb begin
			trial = ((DISC_W+1)'(sq_res_s[k]) << (B + 1)) | ((DISC_W+1)'(1) << (2 * B));
			take  = {1'b0, sq_rem_s[k]} >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_ctl_s[k+1] <= sq_ctl_s[k];
				sq_rem_s[k+1] <= take ? sq_rem_s[k] - trial[DISC_W-1:0] : sq_rem_s[k];
				sq_res_s[k+1] <= take ? sq_res_s[k] | (ROOT_W'(1) << B) : sq_res_s[k];
			end
		end
	end

	// ---------------- root select and scaling ----------------
	logic signed [NUM_W:0] hx, sx, nn, nf;
	ctl_t                  ctl_sel;
	logic [NUM_W-1:0]      num_sel;

	always_comb begin
		hx = (NUM_W+1)'(sq_ctl_s[ROOT_W].h);
		sx = $signed((NUM_W+1)'(sq_res_s[ROOT_W]));
		nn = -hx - sx;
		nf = -hx + sx;
		ctl_sel = sq_ctl_s[ROOT_W];
		if (!nn[NUM_W]) begin
			num_sel = nn[NUM_W-1:0];
		end else begin
			num_sel = nf[NUM_W-1:0];
			if (nf[NUM_W]) begin
				ctl_sel.miss = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_rs <= ctl_sel;
			num_rs <= num_sel;

			dv_ctl_s[0] <= ctl_rs;
			dv_rem_s[0] <= DIV_W'(num_rs) << FRAC_BITS;
			dv_sat_s[0] <= (DIV_W'(num_rs) << FRAC_BITS) >= (DIV_W'(ctl_rs.a) << Q_W);
			dv_q_s[0]   <= '0;
		end
	end

	// ---------------- restoring divide, one quotient bit per stage ----------------
	for (genvar j = 0; j < Q_W; j++) begin : g_div
		localparam int K = Q_W - 1 - j;
		logic [DIV_W-1:0] dvs;
		logic             take;

		always_comb begin
			dvs  = DIV_W'(dv_ctl_s[j].a) << K;
			take = dv_rem_s[j] >= dvs;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_ctl_s[j+1] <= dv_ctl_s[j];
				dv_sat_s[j+1] <= dv_sat_s[j];
				dv_rem_s[j+1] <= take ? dv_rem_s[j] - dvs : dv_rem_s[j];
				dv_q_s[j+1]   <= take ? dv_q_s[j] | (Q_W'(1) << K) : dv_q_s[j];
			end
		end
	end

	// ---------------- output register ----------------
	logic [COORD_W-1:0] t_fin;
	logic               hit_fin;

	always_comb begin
		t_fin   = dv_sat_s[Q_W] ? DIST_MAX : {1'b0, dv_q_s[Q_W]};
		hit_fin = !dv_ctl_s[Q_W].miss
			&& !((dv_ctl_s[Q_W].near > 0) && ($signed(t_fin) > dv_ctl_s[Q_W].near));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result.is_hit   <= hit_fin;
			result.distance <= hit_fin ? $signed(t_fin) : dv_ctl_s[Q_W].near;
		end
	end

endmodule

// ----- bench/ray_sphere_intersect_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_intersect_top_tb
// Self-checking bench for the fixed-point ray/sphere hit test. A driver feeds
// ray/sphere transactions from a queue with random idle bursts; a monitor
// applies random result stalls and compares each result with an exact
// wide-integer computation of the hit distance.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_top_tb
	import rsi_pkg::*;
();

	localparam int IN_W = $bits(in_t);

	typedef struct {
		in_t tr;
		bit  drain;
	} pend_t;

	logic clk;
	logic arst_n;
	in_t  item;
	logic item_valid;
	logic item_stall;
	out_t result;
	logic result_valid;
	logic result_stall;

	pend_t pend_q[$];
	out_t  hit_q[$];
	int    err_cnt = 0;
	int    send_gap;
	int    stall_len;

	ray_sphere_intersect_top DUT (
		.clk(clk), .arst_n(arst_n), .item(item), .item_valid(item_valid),
		.item_stall(item_stall), .result(result), .result_valid(result_valid),
		.result_stall(result_stall)
	);

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	function automatic out_t sphere_hit(in_t t);
		logic signed [131:0] dv[3], pv[3];
		logic signed [131:0] a, rad, ar2, x2, cr, disc, s, cand, h, num, q;
		out_t r;
		dv[0] = t.dir_x; dv[1] = t.dir_y; dv[2] = t.dir_z;
		pv[0] = t.origin_x; pv[1] = t.origin_y; pv[2] = t.origin_z;
		pv[0] = pv[0] - t.center_x;
		pv[1] = pv[1] - t.center_y;
		pv[2] = pv[2] - t.center_z;
		r.is_hit = 1'b0;
		r.distance = t.nearest_so_far;
		a = dv[0] * dv[0] + dv[1] * dv[1] + dv[2] * dv[2];
		if (a == 0)
			return r;
		rad = {101'b0, t.radius};
		ar2 = a * rad * rad;
		cr = dv[1] * pv[2] - dv[2] * pv[1];
		x2 = cr * cr;
		cr = dv[2] * pv[0] - dv[0] * pv[2];
		x2 = x2 + cr * cr;
		cr = dv[0] * pv[1] - dv[1] * pv[0];
		x2 = x2 + cr * cr;
		if (x2 > ar2)
			return r;
		disc = ar2 - x2;
		s = 0;
		for (int b = 63; b >= 0; b--) begin
			cand = s | (132'sd1 <<< b);
			if (cand * cand <= disc)
				s = cand;
		end
		h = dv[0] * pv[0] + dv[1] * pv[1] + dv[2] * pv[2];
		num = -h - s;
		if (num < 0) begin
			num = -h + s;
			if (num < 0)
				return r;
		end
		q = (num <<< FRAC_BITS) / a;
		if (q > 132'sh7FFFFFFF)
			q = 132'sh7FFFFFFF;
		if (t.nearest_so_far > 0 && q > t.nearest_so_far)
			return r;
		r.is_hit = 1'b1;
		r.distance = q[31:0];
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		err_cnt++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		pend_t nxt;
		if (!arst_n) begin
			item <= '0;
			item_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (item_valid && !item_stall)
				hit_q.push_back(sphere_hit(item));
			if (!item_valid || !item_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					item_valid <= 1'b0;
				end else if (pend_q.size() == 0) begin
					item_valid <= 1'b0;
				end else if (pend_q[0].drain && (hit_q.size() != 0 ||
						(item_valid && !item_stall))) begin
					item_valid <= 1'b0;
				end else begin
					nxt = pend_q.pop_front();
					item <= nxt.tr;
					item_valid <= 1'b1;
					if (pend_q.size() > 100 && $urandom_range(0, 7) == 0)
						send_gap <= $urandom_range(1, 10);
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_len <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (hit_q.size() == 0) begin
					report("unexpected transaction", result.distance, 0);
				end else begin
					want = hit_q.pop_front();
					if (result.is_hit !== want.is_hit)
						report("is_hit", 32'(result.is_hit), 32'(want.is_hit));
					if (result.distance !== want.distance)
						report("distance", result.distance, want.distance);
				end
			end
			if (stall_len > 0) begin
				stall_len <= stall_len - 1;
				result_stall <= 1'b1;
			end else if (pend_q.size() > 100 && $urandom_range(0, 9) == 0) begin
				stall_len <= $urandom_range(0, 9);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	task automatic add(in_t t, bit drain = 0);
		pend_t p;
		p.tr = t;
		p.drain = drain;
		pend_q.push_back(p);
	endtask

	function automatic logic signed [31:0] near_coord();
		return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
	endfunction

	function automatic in_t unit_ray(int oz, int dz, int r, int nearest);
		in_t t;
		t = '0;
		t.origin_z = oz;
		t.dir_z = dz;
		t.radius = RAD_W'(r);
		t.nearest_so_far = nearest;
		return t;
	endfunction

	initial begin
		in_t t;
		out_t o;
		arst_n = 1'b0;
		// directed
		add(unit_ray(-5 << 16, 0, 1 << 16, 0));
		add(unit_ray(-5 << 16, 1 << 16, 1 << 16, 0));
		add(unit_ray(-5 << 16, -(1 << 16), 1 << 16, 0));
		add(unit_ray(0, 1 << 16, 1 << 16, 0));
		add(unit_ray(-(1 << 16), 1 << 16, 1 << 16, 0));
		add(unit_ray(-5 << 16, 1 << 16, 1 << 16, 2 << 16));
		add(unit_ray(-5 << 16, 1 << 16, 1 << 16, -7));
		add(unit_ray(-5 << 16, 1 << 16, 1 << 16, 32'h7FFFFFFF));
		add(unit_ray(-32'sh4000_0000, 1, 1 << 16, 0));
		t = unit_ray(-5 << 16, 3 << 16, 1 << 16, 0);
		o = sphere_hit(t);
		t.nearest_so_far = o.distance;
		add(t);
		t = unit_ray(-5 << 16, 1 << 16, 1 << 16, 0);
		t.origin_x = 1 << 16;
		add(t);
		t = unit_ray(-5 << 16, 1 << 16, 1 << 16, 0);
		t.origin_x = 2 << 16;
		add(t, 1);
		t = '1;
		t.radius = '1;
		add(t);
		t = '0;
		t.origin_x = 32'sh8000_0000; t.origin_y = 32'sh7FFF_FFFF;
		t.origin_z = 32'sh8000_0000;
		t.dir_x = 32'sh7FFF_FFFF; t.dir_y = 32'sh8000_0000; t.dir_z = 32'sh7FFF_FFFF;
		t.center_x = 32'sh7FFF_FFFF; t.center_y = 32'sh8000_0000;
		t.center_z = 32'sh7FFF_FFFF;
		t.radius = '1;
		t.nearest_so_far = 32'sh8000_0000;
		add(t);
		t.radius = '0;
		add(t);
		t.dir_x = 32'sh8000_0000; t.dir_y = 32'sh8000_0000; t.dir_z = 32'sh8000_0000;
		t.radius = '1;
		add(t);
		// random
		for (int i = 0; i < 950; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				t = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom});
			end else begin
				t.origin_x = near_coord(); t.origin_y = near_coord();
				t.origin_z = near_coord();
				t.center_x = near_coord(); t.center_y = near_coord();
				t.center_z = near_coord();
				t.dir_x = t.center_x - t.origin_x + (near_coord() >>> $urandom_range(0, 3));
				t.dir_y = t.center_y - t.origin_y + (near_coord() >>> $urandom_range(0, 3));
				t.dir_z = t.center_z - t.origin_z + (near_coord() >>> $urandom_range(0, 3));
				if ($urandom_range(0, 3) == 0) begin
					t.dir_x = -t.dir_x; t.dir_y = -t.dir_y; t.dir_z = -t.dir_z;
				end
				t.dir_x = t.dir_x >>> $urandom_range(0, 8);
				t.dir_y = t.dir_y >>> $urandom_range(0, 8);
				t.dir_z = t.dir_z >>> $urandom_range(0, 8);
				t.radius = RAD_W'($urandom_range(0, 32'h0080_0000));
				case ($urandom_range(0, 2))
					0: t.nearest_so_far = -$urandom_range(0, 1000);
					1: t.nearest_so_far = $urandom_range(0, 32'h0004_0000);
					default: t.nearest_so_far = $urandom;
				endcase
			end
			add(t, i == 500);
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (pend_q.size() == 0);
		@(posedge clk);
		wait (hit_q.size() == 0);
		repeat (150) @(posedge clk);
		if (err_cnt == 0)
			$display("ray_sphere_intersect_top_tb: clean");
		else
			$display("ray_sphere_intersect_top_tb: errors");
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("ray_sphere_intersect_top_tb: errors");
		$finish;
	end

endmodule
